// File: hdl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code builder package
// This package holds the fixed field widths and the result record that the
// sequencer and the output register both use.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int IN_WEIGHT_W = 16;
    localparam int CODE_W      = 15;
    localparam int LEN_W       = 4;

    // One code result, as it leaves the block.
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
        logic                last;
        logic                ovf;
    } result_t;

endpackage

// File: hdl/hcb_out_reg.sv
// ----------------------------------------------------------------------------
// Huffman code builder output register
// This module holds one result transaction until the receiver takes it, so
// that the sequencer can move on as soon as the slot is free.
// ----------------------------------------------------------------------------
module hcb_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hcb_pkg::result_t load_data,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output hcb_pkg::result_t out_data
);
    import hcb_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // The slot is free when it is empty or is being emptied in this cycle.
    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // The payload is only loaded, never reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// File: hdl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// Huffman code builder
// This module stores symbol and weight pairs as leaves, builds a min-heap,
// merges the two lightest nodes until one tree remains, and walks the tree
// left first to give one code result per leaf.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_stall   | symbol, weight, final_symbol
//  output  | out_valid / out_stall | out_symbol, code_bits, code_len,
//          |                       | last_code, overflowed
//
// Each pair is stored as a leaf while there is room. The final pair starts the
// build, which runs on one read port per memory (heap slots, node weights).
// The input is stalled during the whole build and tree walk.
// A result waits in an output register, and a stalled output holds the walk.
// Reset clears the counters and the sequencer; the memories need no clearing.
//
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [hcb_pkg::SYMBOL_W-1:0]     symbol,
    input  logic [hcb_pkg::IN_WEIGHT_W-1:0]  weight,
    input  logic                             final_symbol,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [hcb_pkg::SYMBOL_W-1:0]     out_symbol,
    output logic [hcb_pkg::CODE_W-1:0]       code_bits,
    output logic [hcb_pkg::LEN_W-1:0]        code_len,
    output logic                             last_code,
    output logic                             overflowed
);
    import hcb_pkg::*;

    localparam int HAW    = $clog2(MAX_SYMBOLS);
    localparam int HCW    = $clog2(MAX_SYMBOLS + 1);
    localparam int NDEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int NIW    = $clog2(NDEPTH);
    localparam int NWW    = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int SDEPTH = 2 * MAX_SYMBOLS;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int SPW    = $clog2(SDEPTH + 1);
    localparam int LDW    = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;

    typedef struct packed {
        logic [NIW-1:0]    node;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } walk_t;

    // Sequencer states.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HB     = 5'd1;
    localparam logic [4:0] S_HB_W   = 5'd2;
    localparam logic [4:0] S_SD_L   = 5'd3;
    localparam logic [4:0] S_SD_LW  = 5'd4;
    localparam logic [4:0] S_SD_LC  = 5'd5;
    localparam logic [4:0] S_SD_RW  = 5'd6;
    localparam logic [4:0] S_SD_RC  = 5'd7;
    localparam logic [4:0] S_SD_DEC = 5'd8;
    localparam logic [4:0] S_TM0    = 5'd9;
    localparam logic [4:0] S_TM1    = 5'd10;
    localparam logic [4:0] S_TM2    = 5'd11;
    localparam logic [4:0] S_TM3    = 5'd12;
    localparam logic [4:0] S_MG0    = 5'd13;
    localparam logic [4:0] S_MG1    = 5'd14;
    localparam logic [4:0] S_MG2    = 5'd15;
    localparam logic [4:0] S_SU     = 5'd16;
    localparam logic [4:0] S_SU1    = 5'd17;
    localparam logic [4:0] S_SU2    = 5'd18;
    localparam logic [4:0] S_MCHK   = 5'd19;
    localparam logic [4:0] S_WK0    = 5'd20;
    localparam logic [4:0] S_WK1    = 5'd21;
    localparam logic [4:0] S_WPOP   = 5'd22;
    localparam logic [4:0] S_WE     = 5'd23;
    localparam logic [4:0] S_WCH    = 5'd24;
    localparam logic [4:0] S_WCH2   = 5'd25;
    localparam logic [4:0] S_WOUT   = 5'd26;

    // Where a sift-down returns to.
    localparam logic [1:0] RET_HB = 2'd0;
    localparam logic [1:0] RET_T1 = 2'd1;
    localparam logic [1:0] RET_T2 = 2'd2;

    // Control and working registers.
    logic [4:0]       state_reg, state_next;
    logic [HCW-1:0]   nc_reg, nc_next;
    logic             ovf_reg, ovf_next;
    logic [HCW-1:0]   hc_reg, hc_next;
    logic [NIW-1:0]   next_reg, next_next;
    logic [HAW-1:0]   hb_reg, hb_next;
    logic [HAW-1:0]   at_reg, at_next;
    logic [NIW-1:0]   cur_node_reg, cur_node_next;
    logic [NWW-1:0]   cur_w_reg, cur_w_next;
    logic [HAW-1:0]   best_idx_reg, best_idx_next;
    logic [NIW-1:0]   best_node_reg, best_node_next;
    logic [NWW-1:0]   best_w_reg, best_w_next;
    logic [NIW-1:0]   cand_reg, cand_next;
    logic [1:0]       ret_reg, ret_next;
    logic             phase_reg, phase_next;
    logic [NIW-1:0]   a_reg, a_next;
    logic [NIW-1:0]   b_reg, b_next;
    logic [NWW-1:0]   wa_reg, wa_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    walk_t            e_reg, e_next;

    // Memory ports.
    logic             hs_we, hs_re;
    logic [HAW-1:0]   hs_waddr, hs_raddr;
    logic [NIW-1:0]   hs_wdata, hs_q;
    logic             nw_we, nw_re;
    logic [NIW-1:0]   nw_waddr, nw_raddr;
    logic [NWW-1:0]   nw_wdata, nw_q;
    logic             nt_we, nt_re;
    logic [NIW-1:0]   nt_waddr, nt_raddr;
    logic [NIW-1:0]   nl_wdata, nr_wdata, nl_q, nr_q;
    logic             ls_we, ls_re;
    logic [HAW-1:0]   ls_waddr, ls_raddr;
    logic [SYMBOL_W-1:0] ls_q;
    logic             ws_we, ws_re;
    logic [SAW-1:0]   ws_waddr, ws_raddr;
    walk_t            ws_wdata, ws_q;

    logic [NIW-1:0]   heap_mem  [MAX_SYMBOLS];
    logic [NWW-1:0]   wt_mem    [NDEPTH];
    logic [NIW-1:0]   left_mem  [NDEPTH];
    logic [NIW-1:0]   right_mem [NDEPTH];
    logic [SYMBOL_W-1:0] sym_mem [MAX_SYMBOLS];
    walk_t            stack_mem [SDEPTH];

    // Output register interface.
    logic             out_free;
    logic             out_load;
    result_t          out_ld_data;
    result_t          out_data;

    // Helper values.
    logic             in_acc;
    logic [HAW+1:0]   l_idx, r_idx, hc_ext;
    logic [HAW-1:0]   parent_idx;
    logic [4:0]       sd_ret;
    logic [HCW-1:0]   nc_inc;
    logic [NWW-1:0]   merge_sum;
    logic [SPW:0]     sp_plus2;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign l_idx      = {1'b0, at_reg, 1'b1};
    assign r_idx      = {1'b0, at_reg, 1'b0} + (HAW+2)'(2);
    assign hc_ext     = (HAW+2)'(hc_reg);
    assign parent_idx = (at_reg - HAW'(1)) >> 1;
    assign nc_inc     = nc_reg + HCW'(1);
    assign merge_sum  = wa_reg + nw_q;
    assign sp_plus2   = (SPW+1)'(sp_reg) + (SPW+1)'(2);

    // Return point of a finished sift-down.
    always_comb
    begin
        case (ret_reg)
            RET_HB:  sd_ret = S_HB;
            RET_T1:  sd_ret = S_TM0;
            default: sd_ret = S_MG0;
        endcase
    end

    // Sequencer: load, heapify, extract, merge, sift-up and tree walk.
    always_comb
    begin
        state_next     = state_reg;
        nc_next        = nc_reg;
        ovf_next       = ovf_reg;
        hc_next        = hc_reg;
        next_next      = next_reg;
        hb_next        = hb_reg;
        at_next        = at_reg;
        cur_node_next  = cur_node_reg;
        cur_w_next     = cur_w_reg;
        best_idx_next  = best_idx_reg;
        best_node_next = best_node_reg;
        best_w_next    = best_w_reg;
        cand_next      = cand_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        wa_next        = wa_reg;
        sp_next        = sp_reg;
        e_next         = e_reg;

        hs_we = 1'b0; hs_re = 1'b0; hs_waddr = '0; hs_raddr = '0; hs_wdata = '0;
        nw_we = 1'b0; nw_re = 1'b0; nw_waddr = '0; nw_raddr = '0; nw_wdata = '0;
        nt_we = 1'b0; nt_re = 1'b0; nt_waddr = '0; nt_raddr = '0;
        nl_wdata = '0; nr_wdata = '0;
        ls_we = 1'b0; ls_re = 1'b0; ls_waddr = '0; ls_raddr = '0;
        ws_we = 1'b0; ws_re = 1'b0; ws_waddr = '0; ws_raddr = '0; ws_wdata = '0;

        out_load    = 1'b0;
        out_ld_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (nc_reg < HCW'(MAX_SYMBOLS))
                    begin
                        ls_we    = 1'b1;
                        ls_waddr = HAW'(nc_reg);
                        nw_we    = 1'b1;
                        nw_waddr = NIW'(nc_reg);
                        nw_wdata = NWW'(weight[LDW-1:0]);
                        hs_we    = 1'b1;
                        hs_waddr = HAW'(nc_reg);
                        hs_wdata = NIW'(nc_reg);
                        nc_next  = nc_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_symbol)
                    begin
                        hb_next    = HAW'(nc_next >> 1);
                        hc_next    = nc_next;
                        next_next  = NIW'(nc_next);
                        state_next = S_HB;
                    end
                end
            end

            // Bottom-up heapify, one sift-down per inner node.
            S_HB:
            begin
                if (hb_reg == '0)
                begin
                    state_next = S_MCHK;
                end
                else
                begin
                    at_next       = hb_reg - HAW'(1);
                    cur_node_next = NIW'(hb_reg - HAW'(1));
                    nw_re         = 1'b1;
                    nw_raddr      = NIW'(hb_reg - HAW'(1));
                    hb_next       = hb_reg - HAW'(1);
                    ret_next      = RET_HB;
                    state_next    = S_HB_W;
                end
            end

            S_HB_W:
            begin
                cur_w_next = nw_q;
                state_next = S_SD_L;
            end

            // Sift-down: the moving node stays in cur_node until it settles.
            S_SD_L:
            begin
                if (l_idx >= hc_ext)
                begin
                    hs_we      = 1'b1;
                    hs_waddr   = at_reg;
                    hs_wdata   = cur_node_reg;
                    state_next = sd_ret;
                end
                else
                begin
                    hs_re      = 1'b1;
                    hs_raddr   = HAW'(l_idx);
                    state_next = S_SD_LW;
                end
            end

            S_SD_LW:
            begin
                cand_next  = hs_q;
                nw_re      = 1'b1;
                nw_raddr   = hs_q;
                state_next = S_SD_LC;
            end

            S_SD_LC:
            begin
                if (nw_q < cur_w_reg)
                begin
                    best_idx_next  = HAW'(l_idx);
                    best_node_next = cand_reg;
                    best_w_next    = nw_q;
                end
                else
                begin
                    best_idx_next = at_reg;
                    best_w_next   = cur_w_reg;
                end
                if (r_idx < hc_ext)
                begin
                    hs_re      = 1'b1;
                    hs_raddr   = HAW'(r_idx);
                    state_next = S_SD_RW;
                end
                else
                begin
                    state_next = S_SD_DEC;
                end
            end

            S_SD_RW:
            begin
                cand_next  = hs_q;
                nw_re      = 1'b1;
                nw_raddr   = hs_q;
                state_next = S_SD_RC;
            end

            S_SD_RC:
            begin
                if (nw_q < best_w_reg)
                begin
                    best_idx_next  = HAW'(r_idx);
                    best_node_next = cand_reg;
                    best_w_next    = nw_q;
                end
                state_next = S_SD_DEC;
            end

            S_SD_DEC:
            begin
                hs_we    = 1'b1;
                hs_waddr = at_reg;
                if (best_idx_reg == at_reg)
                begin
                    hs_wdata   = cur_node_reg;
                    state_next = sd_ret;
                end
                else
                begin
                    hs_wdata   = best_node_reg;
                    at_next    = best_idx_reg;
                    state_next = S_SD_L;
                end
            end

            // Extract the minimum: the last entry replaces the root.
            S_TM0:
            begin
                hs_re      = 1'b1;
                hs_raddr   = '0;
                state_next = S_TM1;
            end

            S_TM1:
            begin
                if (!phase_reg)
                begin
                    a_next = hs_q;
                end
                else
                begin
                    b_next = hs_q;
                end
                hs_re      = 1'b1;
                hs_raddr   = HAW'(hc_reg - HCW'(1));
                state_next = S_TM2;
            end

            S_TM2:
            begin
                cur_node_next = hs_q;
                nw_re         = 1'b1;
                nw_raddr      = hs_q;
                hc_next       = hc_reg - HCW'(1);
                state_next    = S_TM3;
            end

            S_TM3:
            begin
                cur_w_next = nw_q;
                at_next    = '0;
                ret_next   = phase_reg ? RET_T2 : RET_T1;
                phase_next = 1'b1;
                state_next = S_SD_L;
            end

            // Merge the two minima into a new node.
            S_MG0:
            begin
                nw_re      = 1'b1;
                nw_raddr   = a_reg;
                state_next = S_MG1;
            end

            S_MG1:
            begin
                wa_next    = nw_q;
                nw_re      = 1'b1;
                nw_raddr   = b_reg;
                state_next = S_MG2;
            end

            S_MG2:
            begin
                nw_we         = 1'b1;
                nw_waddr      = next_reg;
                nw_wdata      = merge_sum;
                nt_we         = 1'b1;
                nt_waddr      = next_reg;
                nl_wdata      = a_reg;
                nr_wdata      = b_reg;
                cur_w_next    = merge_sum;
                cur_node_next = next_reg;
                at_next       = HAW'(hc_reg);
                hc_next       = hc_reg + HCW'(1);
                state_next    = S_SU;
            end

            // Sift-up of the merged node.
            S_SU:
            begin
                if (at_reg == '0)
                begin
                    hs_we      = 1'b1;
                    hs_waddr   = '0;
                    hs_wdata   = cur_node_reg;
                    next_next  = next_reg + NIW'(1);
                    state_next = S_MCHK;
                end
                else
                begin
                    hs_re      = 1'b1;
                    hs_raddr   = parent_idx;
                    state_next = S_SU1;
                end
            end

            S_SU1:
            begin
                cand_next  = hs_q;
                nw_re      = 1'b1;
                nw_raddr   = hs_q;
                state_next = S_SU2;
            end

            S_SU2:
            begin
                hs_we    = 1'b1;
                hs_waddr = at_reg;
                if (cur_w_reg < nw_q)
                begin
                    hs_wdata   = cand_reg;
                    at_next    = parent_idx;
                    state_next = S_SU;
                end
                else
                begin
                    hs_wdata   = cur_node_reg;
                    next_next  = next_reg + NIW'(1);
                    state_next = S_MCHK;
                end
            end

            S_MCHK:
            begin
                phase_next = 1'b0;
                if (hc_reg > HCW'(1))
                begin
                    state_next = S_TM0;
                end
                else
                begin
                    state_next = S_WK0;
                end
            end

            // Tree walk, depth first with the left branch first.
            S_WK0:
            begin
                hs_re      = 1'b1;
                hs_raddr   = '0;
                state_next = S_WK1;
            end

            S_WK1:
            begin
                ws_we         = 1'b1;
                ws_waddr      = '0;
                ws_wdata.node = hs_q;
                ws_wdata.len  = '0;
                ws_wdata.code = '0;
                sp_next       = SPW'(1);
                state_next    = S_WPOP;
            end

            S_WPOP:
            begin
                if (sp_reg == '0)
                begin
                    nc_next    = '0;
                    hc_next    = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ws_re      = 1'b1;
                    ws_raddr   = SAW'(sp_reg - SPW'(1));
                    sp_next    = sp_reg - SPW'(1);
                    state_next = S_WE;
                end
            end

            S_WE:
            begin
                e_next = ws_q;
                if (ws_q.node < NIW'(nc_reg))
                begin
                    ls_re      = 1'b1;
                    ls_raddr   = HAW'(ws_q.node);
                    state_next = S_WOUT;
                end
                else if (sp_plus2 <= (SPW+1)'(SDEPTH))
                begin
                    nt_re      = 1'b1;
                    nt_raddr   = ws_q.node;
                    state_next = S_WCH;
                end
                else
                begin
                    state_next = S_WPOP;
                end
            end

            // Push the right child first so that the left one pops first.
            S_WCH:
            begin
                ws_we         = 1'b1;
                ws_waddr      = SAW'(sp_reg);
                ws_wdata.node = nr_q;
                ws_wdata.len  = e_reg.len + LEN_W'(1);
                ws_wdata.code = {e_reg.code[CODE_W-2:0], 1'b1};
                sp_next       = sp_reg + SPW'(1);
                state_next    = S_WCH2;
            end

            S_WCH2:
            begin
                ws_we         = 1'b1;
                ws_waddr      = SAW'(sp_reg);
                ws_wdata.node = nl_q;
                ws_wdata.len  = e_reg.len + LEN_W'(1);
                ws_wdata.code = {e_reg.code[CODE_W-2:0], 1'b0};
                sp_next       = sp_reg + SPW'(1);
                state_next    = S_WPOP;
            end

            // A leaf result waits here for a free output slot.
            S_WOUT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_ld_data.symbol = ls_q;
                    out_ld_data.code   = e_reg.code;
                    out_ld_data.len    = e_reg.len;
                    out_ld_data.last   = (sp_reg == '0);
                    out_ld_data.ovf    = ovf_reg;
                    state_next         = S_WPOP;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nc_reg    <= '0;
            ovf_reg   <= 1'b0;
            hc_reg    <= '0;
            sp_reg    <= '0;
            phase_reg <= 1'b0;
            ret_reg   <= RET_HB;
        end
        else
        begin
            state_reg <= state_next;
            nc_reg    <= nc_next;
            ovf_reg   <= ovf_next;
            hc_reg    <= hc_next;
            sp_reg    <= sp_next;
            phase_reg <= phase_next;
            ret_reg   <= ret_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge clk)
    begin
        next_reg      <= next_next;
        hb_reg        <= hb_next;
        at_reg        <= at_next;
        cur_node_reg  <= cur_node_next;
        cur_w_reg     <= cur_w_next;
        best_idx_reg  <= best_idx_next;
        best_node_reg <= best_node_next;
        best_w_reg    <= best_w_next;
        cand_reg      <= cand_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        wa_reg        <= wa_next;
        e_reg         <= e_next;
    end

    // Heap slot memory.
    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            heap_mem[hs_waddr] <= hs_wdata;
        end
        if (hs_re)
        begin
            hs_q <= heap_mem[hs_raddr];
        end
    end

    // Node weight memory.
    always_ff @(posedge clk)
    begin
        if (nw_we)
        begin
            wt_mem[nw_waddr] <= nw_wdata;
        end
        if (nw_re)
        begin
            nw_q <= wt_mem[nw_raddr];
        end
    end

    // Child link memories, written and read as a pair.
    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            left_mem[nt_waddr]  <= nl_wdata;
            right_mem[nt_waddr] <= nr_wdata;
        end
        if (nt_re)
        begin
            nl_q <= left_mem[nt_raddr];
            nr_q <= right_mem[nt_raddr];
        end
    end

    // Leaf symbol memory.
    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            sym_mem[ls_waddr] <= symbol;
        end
        if (ls_re)
        begin
            ls_q <= sym_mem[ls_raddr];
        end
    end

    // Walk stack memory.
    always_ff @(posedge clk)
    begin
        if (ws_we)
        begin
            stack_mem[ws_waddr] <= ws_wdata;
        end
        if (ws_re)
        begin
            ws_q <= stack_mem[ws_raddr];
        end
    end

    // Output register and result fields.
    hcb_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_ld_data),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_symbol = out_data.symbol;
    assign code_bits  = out_data.code;
    assign code_len   = out_data.len;
    assign last_code  = out_data.last;
    assign overflowed = out_data.ovf;

endmodule
